FILE: rtl/core/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants of the vertex rotate and project block.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int COORD_W  = 16;
    localparam int TRIG_W   = 16;
    localparam int SCALE_W  = 6;
    localparam int CENTRE_W = 6;
    localparam int PIX_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PIX_MIN = -2048;
    localparam int PIX_MAX = 2047;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd4;

    // Register values after reset.
    localparam logic signed [TRIG_W-1:0] COS_RESET      = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET      = 16'sd0;
    localparam logic [SCALE_W-1:0]       SCALE_RESET    = 6'd5;
    localparam logic [CENTRE_W-1:0]      CENTRE_X_RESET = 6'd32;
    localparam logic [CENTRE_W-1:0]      CENTRE_Y_RESET = 6'd32;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    on_panel;
    } pixel_t;

endpackage

FILE: rtl/core/vertex_rotate_project_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project_top
// Rotates a 3D vertex about Z, X and Y and projects it onto a square panel.
// ----------------------------------------------------------------------------
// The block takes one vertex beat per clock cycle while the output side does
// not stall and returns one pixel beat per vertex, in order, through an
// eight-stage register pipeline. Rotations about Z and X each take a stage
// for four products and one for two sums and the floor back to Q7.8, the
// one about Y a stage for two products and one for a sum and floor; then
// one stage multiplies by the scale and a last stage adds the screen centre,
// truncates toward zero, saturates and tests the panel bounds. Every stage
// holds its own valid bit, so a stall at the output only stops the stages
// that hold data and empty stages keep taking vertices. The trig, scale and
// centre registers are written through the configuration port, which is
// always ready; they should only be changed while no vertex is in flight.
module vertex_rotate_project_top #(
    parameter int PANEL_SIZE     = 64,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  vrp_pkg::vertex_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output vrp_pkg::pixel_t                      out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import vrp_pkg::*;

    localparam int F   = TRIG_FRAC_BITS;
    localparam int NST = 8;

    // Widths through the rotation chain. Each stage forms a sum of two
    // products with a 16-bit factor and drops F fraction bits.
    localparam int PW1 = COORD_W + TRIG_W;
    localparam int SW1 = PW1 + 1;
    localparam int W1  = SW1 - F;
    localparam int A2  = (W1 > COORD_W) ? W1 : COORD_W;
    localparam int PW2 = A2 + TRIG_W;
    localparam int SW2 = PW2 + 1;
    localparam int W2  = SW2 - F;
    localparam int A3  = (W1 > W2) ? W1 : W2;
    localparam int PW3 = A3 + TRIG_W;
    localparam int SW3 = PW3 + 1;
    localparam int W3  = SW3 - F;
    // Scale product, centre sum and pixel widths.
    localparam int A4  = (W3 > W2) ? W3 : W2;
    localparam int MW  = A4 + SCALE_W + 1;
    localparam int CW  = CENTRE_W + 8 + 1;
    localparam int TW  = ((MW > CW) ? MW : CW) + 1;
    localparam int QW  = TW - 8;
    localparam int XW  = (QW > PIX_W) ? QW : PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [SCALE_W-1:0]       scale_reg;
    logic [CENTRE_W-1:0]      centre_x_reg;
    logic [CENTRE_W-1:0]      centre_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= COS_RESET;
            sin_reg      <= SIN_RESET;
            scale_reg    <= SCALE_RESET;
            centre_x_reg <= CENTRE_X_RESET;
            centre_y_reg <= CENTRE_Y_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COS:      cos_reg      <= cfg_data[TRIG_W-1:0];
                REG_SIN:      sin_reg      <= cfg_data[TRIG_W-1:0];
                REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_CENTRE_X: centre_x_reg <= cfg_data[CENTRE_W-1:0];
                REG_CENTRE_Y: centre_y_reg <= cfg_data[CENTRE_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control. A stage loads when it is empty or when the stage
    // after it loads, so bubbles close up behind a stalled output beat.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products of the rotation about Z.
    // ------------------------------------------------------------------
    logic signed [PW1-1:0]     s1_cx_reg, s1_sy_reg, s1_sx_reg, s1_cy_reg;
    logic signed [COORD_W-1:0] s1_z_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_cx_reg <= cos_reg * in_data.vertex_x;
            s1_sy_reg <= sin_reg * in_data.vertex_y;
            s1_sx_reg <= sin_reg * in_data.vertex_x;
            s1_cy_reg <= cos_reg * in_data.vertex_y;
            s1_z_reg  <= in_data.vertex_z;
        end
    end

    // Stage 2: sums and floor back to Q7.8.
    logic signed [SW1-1:0]     s2_xsum, s2_ysum;
    logic signed [W1-1:0]      s2_x1_reg, s2_y1_reg;
    logic signed [COORD_W-1:0] s2_z_reg;

    assign s2_xsum = SW1'(s1_cx_reg) - SW1'(s1_sy_reg);
    assign s2_ysum = SW1'(s1_sx_reg) + SW1'(s1_cy_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_x1_reg <= s2_xsum[SW1-1:F];
            s2_y1_reg <= s2_ysum[SW1-1:F];
            s2_z_reg  <= s1_z_reg;
        end
    end

    // Stage 3: products of the rotation about X.
    logic signed [PW2-1:0] s3_cy_reg, s3_sz_reg, s3_sy_reg, s3_cz_reg;
    logic signed [W1-1:0]  s3_x1_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_cy_reg <= cos_reg * s2_y1_reg;
            s3_sz_reg <= sin_reg * s2_z_reg;
            s3_sy_reg <= sin_reg * s2_y1_reg;
            s3_cz_reg <= cos_reg * s2_z_reg;
            s3_x1_reg <= s2_x1_reg;
        end
    end

    // Stage 4: sums and floor.
    logic signed [SW2-1:0] s4_ysum, s4_zsum;
    logic signed [W2-1:0]  s4_y2_reg, s4_z2_reg;
    logic signed [W1-1:0]  s4_x1_reg;

    assign s4_ysum = SW2'(s3_cy_reg) - SW2'(s3_sz_reg);
    assign s4_zsum = SW2'(s3_sy_reg) + SW2'(s3_cz_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_y2_reg <= s4_ysum[SW2-1:F];
            s4_z2_reg <= s4_zsum[SW2-1:F];
            s4_x1_reg <= s3_x1_reg;
        end
    end

    // Stage 5: products of the rotation about Y; only x survives it.
    logic signed [PW3-1:0] s5_cx_reg, s5_sz_reg;
    logic signed [W2-1:0]  s5_y2_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_cx_reg <= cos_reg * s4_x1_reg;
            s5_sz_reg <= sin_reg * s4_z2_reg;
            s5_y2_reg <= s4_y2_reg;
        end
    end

    // Stage 6: sum and floor.
    logic signed [SW3-1:0] s6_xsum;
    logic signed [W3-1:0]  s6_x3_reg;
    logic signed [W2-1:0]  s6_y2_reg;

    assign s6_xsum = SW3'(s5_cx_reg) + SW3'(s5_sz_reg);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_x3_reg <= s6_xsum[SW3-1:F];
            s6_y2_reg <= s5_y2_reg;
        end
    end

    // Stage 7: multiply by the scale.
    logic signed [SCALE_W:0] scale_s;
    logic signed [MW-1:0]    s7_px_reg, s7_py_reg;

    assign scale_s = $signed({1'b0, scale_reg});

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_px_reg <= s6_x3_reg * scale_s;
            s7_py_reg <= s6_y2_reg * scale_s;
        end
    end

    // Stage 8: add the centre, truncate toward zero, saturate, test bounds.
    logic signed [TW-1:0] tot_x, tot_y, bias_x, bias_y;
    logic signed [QW-1:0] q_x, q_y;
    logic signed [XW-1:0] e_x, e_y;
    logic signed [XW-1:0] pix_lo, pix_hi, panel_end;
    logic signed [PIX_W-1:0] sat_x, sat_y;
    pixel_t out_next, out_reg;

    assign pix_lo    = XW'(PIX_MIN);
    assign pix_hi    = XW'(PIX_MAX);
    assign panel_end = XW'(PANEL_SIZE);

    always_comb
    begin
        tot_x  = TW'($signed({1'b0, centre_x_reg, 8'b0})) + TW'(s7_px_reg);
        tot_y  = TW'($signed({1'b0, centre_y_reg, 8'b0})) + TW'(s7_py_reg);
        // A negative total is biased so that the floor shift truncates toward zero.
        bias_x = tot_x + (tot_x[TW-1] ? TW'(255) : TW'(0));
        bias_y = tot_y + (tot_y[TW-1] ? TW'(255) : TW'(0));
        q_x    = bias_x[TW-1:8];
        q_y    = bias_y[TW-1:8];
        e_x    = XW'(q_x);
        e_y    = XW'(q_y);

        if (e_x < pix_lo)
            sat_x = PIX_W'(PIX_MIN);
        else if (e_x > pix_hi)
            sat_x = PIX_W'(PIX_MAX);
        else
            sat_x = e_x[PIX_W-1:0];

        if (e_y < pix_lo)
            sat_y = PIX_W'(PIX_MIN);
        else if (e_y > pix_hi)
            sat_y = PIX_W'(PIX_MAX);
        else
            sat_y = e_y[PIX_W-1:0];

        out_next.pixel_x  = sat_x;
        out_next.pixel_y  = sat_y;
        out_next.on_panel = !e_x[XW-1] && (e_x < panel_end)
                         && !e_y[XW-1] && (e_y < panel_end);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule
